FILE: rtl/shl_pkg.sv
// Shared types and constants for the stepper homing sequencer.
// No dependencies; used by shl_cfg, shl_core and stepper_limit_switch_homing.
package shl_pkg;

	localparam int LeaveMinPulses = 50;
	localparam int SlowFactor     = 10;

	localparam int TravelW = 24;
	localparam int StepsW  = 16;
	localparam int HalfW   = 19;
	localparam int PeriodW = 16;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 24;

	localparam logic [TravelW-1:0] MaxTravelReset = 24'd100000;
	localparam logic [TravelW-1:0] TravelSat      = {TravelW{1'b1}};
	localparam logic [StepsW-1:0]  StepsSat       = {StepsW{1'b1}};

	typedef enum logic [1:0] {
		CMD_TICK         = 2'd0,
		CMD_START_NORMAL = 2'd1,
		CMD_START_CAL    = 2'd2,
		CMD_ABORT        = 2'd3
	} cmd_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MAX_TRAVEL    = 2'd0,
		REG_BACKOFF_BASE  = 2'd1,
		REG_CENTER        = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE           = 4'd0,
		PH_BACKOFF        = 4'd1,
		PH_SEEK           = 4'd2,
		PH_BASE_EXTRA     = 4'd3,
		PH_CENTER         = 4'd4,
		PH_CAL_SEEK_BASE  = 4'd5,
		PH_CAL_LEAVE_BASE = 4'd6,
		PH_CAL_SEEK_FAR   = 4'd7,
		PH_CAL_LEAVE_FAR  = 4'd8,
		PH_CAL_SEEK_AGAIN = 4'd9,
		PH_CAL_BASE_EXTRA = 4'd10,
		PH_CAL_CENTER     = 4'd11
	} phase_t;

	typedef struct packed {
		logic [TravelW-1:0] max_travel_steps;
		logic [StepsW-1:0]  backoff_base_steps;
		logic [StepsW-1:0]  center_steps;
	} cfg_t;

	typedef struct packed {
		phase_t             phase;
		logic [HalfW-1:0]   half_period;
		logic [HalfW-1:0]   tick_count;
		logic               pulse_high;
		logic [TravelW-1:0] seek_count;
		logic [StepsW-1:0]  fixed_count;
		logic               dir_base;
		logic [StepsW-1:0]  center_pos;
	} state_t;

	typedef struct packed {
		logic               step_level;
		logic               toward_base;
		logic               busy_res;
		logic               done_ok;
		logic               failed;
		logic [StepsW-1:0]  position;
		logic [TravelW-1:0] travel_count;
		logic [3:0]         phase_now;
	} result_t;

endpackage

FILE: rtl/shl_cfg.sv
// Configuration register file of the homing sequencer.
// Depends on shl_pkg.
module shl_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [shl_pkg::CfgIdxW-1:0]   cfg_idx,
	input  logic [shl_pkg::CfgDataW-1:0]  cfg_data,
	output shl_pkg::cfg_t                 cfg
);

	shl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_travel_steps   <= shl_pkg::MaxTravelReset;
			cfg_q.backoff_base_steps <= '0;
			cfg_q.center_steps       <= '0;
		end else if (cfg_we) begin
			case (shl_pkg::reg_idx_t'(cfg_idx))
				shl_pkg::REG_MAX_TRAVEL: begin
					cfg_q.max_travel_steps <= cfg_data[shl_pkg::TravelW-1:0];
				end
				shl_pkg::REG_BACKOFF_BASE: begin
					cfg_q.backoff_base_steps <= cfg_data[shl_pkg::StepsW-1:0];
				end
				shl_pkg::REG_CENTER: begin
					cfg_q.center_steps <= cfg_data[shl_pkg::StepsW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/shl_core.sv
// Per-tick next-state and result logic of the homing sequencer.
// Purely combinational; depends on shl_pkg.
module shl_core (
	input  shl_pkg::state_t               cur,
	input  shl_pkg::cfg_t                 cfg,
	input  shl_pkg::cmd_t                 cmd,
	input  logic                          limit_hit,
	input  logic [shl_pkg::PeriodW-1:0]   pulse_period,
	output shl_pkg::state_t               nxt,
	output shl_pkg::result_t              res
);

	logic [shl_pkg::HalfW-1:0] half_eff;
	logic [shl_pkg::HalfW-1:0] half_norm;
	logic [shl_pkg::HalfW-1:0] half_cal;
	logic [shl_pkg::HalfW-1:0] tick_dec;
	logic                      is_seek;
	logic                      complete;
	logic                      start_p;
	logic                      done;
	logic                      fail;

	assign half_eff  = (cur.half_period == '0) ? shl_pkg::HalfW'(1) : cur.half_period;
	assign half_norm = shl_pkg::HalfW'(pulse_period >> 1);
	assign half_cal  = shl_pkg::HalfW'(half_norm * shl_pkg::HalfW'(shl_pkg::SlowFactor));
	assign tick_dec  = cur.tick_count - shl_pkg::HalfW'(1);
	assign is_seek   = (cur.phase == shl_pkg::PH_SEEK) || (cur.phase == shl_pkg::PH_CAL_SEEK_BASE)
		|| (cur.phase == shl_pkg::PH_CAL_SEEK_FAR) || (cur.phase == shl_pkg::PH_CAL_SEEK_AGAIN);

	// next state
	always_comb begin
		nxt      = cur;
		done     = 1'b0;
		fail     = 1'b0;
		complete = 1'b0;
		start_p  = 1'b0;

		if (cur.phase == shl_pkg::PH_IDLE) begin
			if (cmd == shl_pkg::CMD_START_NORMAL || cmd == shl_pkg::CMD_START_CAL) begin
				nxt.half_period = (cmd == shl_pkg::CMD_START_CAL) ? half_cal : half_norm;
				nxt.tick_count  = '0;
				nxt.pulse_high  = 1'b0;
				nxt.seek_count  = '0;
				nxt.fixed_count = '0;
				nxt.dir_base    = 1'b1;
				if (cmd == shl_pkg::CMD_START_CAL) begin
					nxt.phase = shl_pkg::PH_CAL_SEEK_BASE;
				end else if (limit_hit) begin
					nxt.phase    = shl_pkg::PH_BACKOFF;
					nxt.dir_base = 1'b0;
				end else begin
					nxt.phase = shl_pkg::PH_SEEK;
				end
			end
		end else if (cmd == shl_pkg::CMD_ABORT && is_seek) begin
			fail = 1'b1;
		end else if (cur.pulse_high || cur.tick_count != '0) begin
			// pulse in flight; it completes on its last low tick
			if (cur.tick_count != '0) begin
				nxt.tick_count = tick_dec;
				complete = !cur.pulse_high && tick_dec == '0;
			end else begin
				nxt.pulse_high = 1'b0;
				nxt.tick_count = half_eff - shl_pkg::HalfW'(1);
				complete = (half_eff == shl_pkg::HalfW'(1));
			end
			if (complete) begin
				case (cur.phase)
					shl_pkg::PH_BACKOFF, shl_pkg::PH_BASE_EXTRA,
					shl_pkg::PH_CAL_BASE_EXTRA: begin
						if (cur.fixed_count < shl_pkg::StepsSat)
							nxt.fixed_count = cur.fixed_count + 1'b1;
					end
					shl_pkg::PH_CENTER, shl_pkg::PH_CAL_CENTER: begin
						if (cur.center_pos < shl_pkg::StepsSat)
							nxt.center_pos = cur.center_pos + 1'b1;
					end
					shl_pkg::PH_CAL_LEAVE_BASE, shl_pkg::PH_CAL_LEAVE_FAR: begin
						if (cur.fixed_count < shl_pkg::StepsSat)
							nxt.fixed_count = cur.fixed_count + 1'b1;
						if (cur.seek_count < shl_pkg::TravelSat)
							nxt.seek_count = cur.seek_count + 1'b1;
					end
					shl_pkg::PH_SEEK, shl_pkg::PH_CAL_SEEK_BASE, shl_pkg::PH_CAL_SEEK_FAR,
					shl_pkg::PH_CAL_SEEK_AGAIN: begin
						if (cur.seek_count < shl_pkg::TravelSat)
							nxt.seek_count = cur.seek_count + 1'b1;
						if (nxt.seek_count > cfg.max_travel_steps)
							fail = 1'b1;
					end
					default: begin
					end
				endcase
			end
		end else begin
			// decision tick: start a pulse or change phase
			case (cur.phase)
				shl_pkg::PH_BACKOFF: begin
					if (cur.fixed_count >= cfg.center_steps) begin
						nxt.phase       = shl_pkg::PH_SEEK;
						nxt.dir_base    = 1'b1;
						nxt.seek_count  = '0;
						nxt.fixed_count = '0;
					end else start_p = 1'b1;
				end
				shl_pkg::PH_SEEK, shl_pkg::PH_CAL_SEEK_AGAIN: begin
					if (limit_hit) begin
						nxt.phase = (cur.phase == shl_pkg::PH_SEEK) ? shl_pkg::PH_BASE_EXTRA
							: shl_pkg::PH_CAL_BASE_EXTRA;
						nxt.fixed_count = '0;
					end else start_p = 1'b1;
				end
				shl_pkg::PH_BASE_EXTRA, shl_pkg::PH_CAL_BASE_EXTRA: begin
					if (cur.fixed_count >= cfg.backoff_base_steps) begin
						nxt.phase = (cur.phase == shl_pkg::PH_BASE_EXTRA) ? shl_pkg::PH_CENTER
							: shl_pkg::PH_CAL_CENTER;
						nxt.dir_base   = 1'b0;
						nxt.center_pos = '0;
					end else start_p = 1'b1;
				end
				shl_pkg::PH_CENTER, shl_pkg::PH_CAL_CENTER: begin
					if (cur.center_pos >= cfg.center_steps) begin
						nxt.phase = shl_pkg::PH_IDLE;
						done      = 1'b1;
					end else start_p = 1'b1;
				end
				shl_pkg::PH_CAL_SEEK_BASE, shl_pkg::PH_CAL_SEEK_FAR: begin
					if (limit_hit) begin
						if (cur.phase == shl_pkg::PH_CAL_SEEK_BASE) begin
							nxt.phase    = shl_pkg::PH_CAL_LEAVE_BASE;
							nxt.dir_base = 1'b0;
						end else begin
							nxt.phase    = shl_pkg::PH_CAL_LEAVE_FAR;
							nxt.dir_base = 1'b1;
						end
						nxt.seek_count  = '0;
						nxt.fixed_count = '0;
					end else start_p = 1'b1;
				end
				shl_pkg::PH_CAL_LEAVE_BASE, shl_pkg::PH_CAL_LEAVE_FAR: begin
					if (cur.fixed_count >= shl_pkg::StepsW'(shl_pkg::LeaveMinPulses) && !limit_hit)
						nxt.phase = (cur.phase == shl_pkg::PH_CAL_LEAVE_BASE)
							? shl_pkg::PH_CAL_SEEK_FAR : shl_pkg::PH_CAL_SEEK_AGAIN;
					else start_p = 1'b1;
				end
				default: begin
					nxt.phase = shl_pkg::PH_IDLE;
				end
			endcase
			if (start_p) begin
				nxt.pulse_high = 1'b1;
				nxt.tick_count = half_eff - shl_pkg::HalfW'(1);
			end
		end

		if (fail) begin
			nxt.phase      = shl_pkg::PH_IDLE;
			nxt.pulse_high = 1'b0;
			nxt.tick_count = '0;
		end
	end

	// result fields
	always_comb begin
		res.step_level   = nxt.pulse_high;
		res.toward_base  = nxt.dir_base;
		res.busy_res     = (nxt.phase != shl_pkg::PH_IDLE);
		res.done_ok      = done;
		res.failed       = fail;
		res.position     = nxt.center_pos;
		res.travel_count = nxt.seek_count;
		res.phase_now    = nxt.phase;
	end

endmodule

FILE: rtl/stepper_limit_switch_homing.sv
// Top level of the stepper homing sequencer: input stage, sequencer state, result stage.
// Depends on shl_pkg, shl_cfg and shl_core.

// Each input beat is one timebase tick; the block takes one beat per clock while
// in_ready is high and returns exactly one result beat per tick, through one
// input register and one result register. The sequencer state is updated as a
// tick moves from the input register into the result register, so ticks run back
// to back; a stalled output holds both stages and drops in_ready only once both
// are full. Configuration writes take effect at once and are meant for idle
// periods only.
module stepper_limit_switch_homing (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [shl_pkg::CfgIdxW-1:0]   cfg_idx,
	input  logic [shl_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    cmd,
	input  logic                          limit_hit,
	input  logic [15:0]                   pulse_period,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          step_level,
	output logic                          toward_base,
	output logic                          busy_res,
	output logic                          done_ok,
	output logic                          failed,
	output logic [15:0]                   position,
	output logic [23:0]                   travel_count,
	output logic [3:0]                    phase_now
);

	shl_pkg::cfg_t    cfg;
	shl_pkg::state_t  state_q;
	shl_pkg::state_t  state_nxt;
	shl_pkg::result_t res_nxt;
	shl_pkg::result_t res_s2;

	logic        valid_s1;
	logic        valid_s2;
	logic [1:0]  cmd_s1;
	logic        limit_s1;
	logic [15:0] period_s1;
	logic        adv_s2;
	logic        adv_s1;

	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	shl_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	shl_core u_core (
		.cur          (state_q),
		.cfg          (cfg),
		.cmd          (shl_pkg::cmd_t'(cmd_s1)),
		.limit_hit    (limit_s1),
		.pulse_period (period_s1),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1    <= cmd;
			limit_s1  <= limit_hit;
			period_s1 <= pulse_period;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= shl_pkg::PH_IDLE;
			state_q.half_period <= '0;
			state_q.tick_count  <= '0;
			state_q.pulse_high  <= 1'b0;
			state_q.seek_count  <= '0;
			state_q.fixed_count <= '0;
			state_q.dir_base    <= 1'b1;
			state_q.center_pos  <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid    = valid_s2;
	assign step_level   = res_s2.step_level;
	assign toward_base  = res_s2.toward_base;
	assign busy_res     = res_s2.busy_res;
	assign done_ok      = res_s2.done_ok;
	assign failed       = res_s2.failed;
	assign position     = res_s2.position;
	assign travel_count = res_s2.travel_count;
	assign phase_now    = res_s2.phase_now;

endmodule
